### hw/rtl/msr_pkg.sv
// shared types and constants for the modular square root block
package msr_pkg;

    localparam int unsigned NONRES_LIMIT = 4096;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

endpackage

### hw/rtl/msr_mulmod.sv
// bit-serial modular multiplier, one shared add-and-reduce per cycle
module msr_mulmod
    import msr_pkg::*;
#(
    parameter int WIDTH = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic [WIDTH-1:0] p,
    output mm_stat_t         stat,
    output logic [WIDTH-1:0] prod
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [CW-1:0]    cnt_reg;
    logic             phase_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [WIDTH-1:0] opnd;
    logic [WIDTH:0]   sum;
    logic [WIDTH-1:0] red;

    // phase 0 doubles the accumulator, phase 1 adds a when the bit is set
    always_comb
    begin
        opnd = phase_reg ? a_reg : acc_reg;
        sum  = {1'b0, acc_reg} + {1'b0, opnd};
        if (sum >= {1'b0, p})
        begin
            red = WIDTH'(sum - {1'b0, p});
        end
        else
        begin
            red = sum[WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= CW'(WIDTH);
        end
        else if (busy_reg)
        begin
            phase_reg <= ~phase_reg;
            if (phase_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                acc_reg <= red;
            end
            else
            begin
                if (b_reg[WIDTH-1])
                begin
                    acc_reg <= red;
                end
                b_reg <= b_reg << 1;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = acc_reg;

endmodule

### hw/rtl/modular_square_root.sv
// each modular multiply runs in the shared serial multiplier
// an exponentiation costs up to two multiplies per exponent bit; a rejected input
// needs no multiply at all
// throughput: one word at a time; a new word is taken once the previous one is finished
// reset: modulus is 3, the sequencer is idle and no result word is pending
module modular_square_root
    import msr_pkg::*;
#(
    parameter int WIDTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [63:0] cfg_wdata,     // modulus
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // root
);

    localparam int SW = $clog2(WIDTH + 1);

    typedef enum logic [21:0] {
        ST_IDLE    = 22'd1 << 0,
        ST_INIT    = 22'd1 << 1,
        ST_FACTOR  = 22'd1 << 2,
        ST_POW_CHK = 22'd1 << 3,
        ST_POW_ACC = 22'd1 << 4,
        ST_POW_SQ  = 22'd1 << 5,
        ST_MWAIT   = 22'd1 << 6,
        ST_S1_SQ   = 22'd1 << 7,
        ST_ZCHK    = 22'd1 << 8,
        ST_ZTEST   = 22'd1 << 9,
        ST_GOT_C   = 22'd1 << 10,
        ST_GOT_R   = 22'd1 << 11,
        ST_GOT_T   = 22'd1 << 12,
        ST_LOOP    = 22'd1 << 13,
        ST_TT_SQ   = 22'd1 << 14,
        ST_BSQ     = 22'd1 << 15,
        ST_BSQ_R   = 22'd1 << 16,
        ST_B2      = 22'd1 << 17,
        ST_UPD_R   = 22'd1 << 18,
        ST_UPD_T   = 22'd1 << 19,
        ST_FIN     = 22'd1 << 20,
        ST_OUT     = 22'd1 << 21
    } state_t;

    state_t           state_reg;
    state_t           ret_reg;
    state_t           pow_ret_reg;
    logic [WIDTH-1:0] p_reg;
    logic [63:0]      n_reg;
    logic [WIDTH-1:0] q_reg;
    logic [SW-1:0]    s_reg;
    logic [SW-1:0]    m_reg;
    logic [SW-1:0]    i_reg;
    logic [SW-1:0]    cnt_reg;
    logic [WIDTH-1:0] z_reg;
    logic [WIDTH-1:0] c_reg;
    logic [WIDTH-1:0] r_reg;
    logic [WIDTH-1:0] t_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] b2_reg;
    logic [WIDTH-1:0] base_reg;
    logic [WIDTH-1:0] exp_reg;
    logic [WIDTH-1:0] pacc_reg;
    logic [WIDTH-1:0] res_reg;
    logic [WIDTH-1:0] out_reg;
    logic             out_valid_reg;
    logic             mm_start_reg;
    logic [WIDTH-1:0] mma_reg;
    logic [WIDTH-1:0] mmb_reg;

    mm_stat_t         mm_stat;
    logic [WIDTH-1:0] mm_prod;
    logic [WIDTH-1:0] n_low;
    logic [SW-1:0]    i_next;
    logic             bad_input;

    msr_mulmod #(.WIDTH(WIDTH)) u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start_reg),
        .a     (mma_reg),
        .b     (mmb_reg),
        .p     (p_reg),
        .stat  (mm_stat),
        .prod  (mm_prod)
    );

    assign n_low     = n_reg[WIDTH-1:0];
    assign i_next    = i_reg + 1'b1;
    assign bad_input = (n_reg >= 64'(p_reg)) || (p_reg < WIDTH'(3)) || !p_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            pow_ret_reg   <= ST_IDLE;
            p_reg         <= WIDTH'(3);
            out_valid_reg <= 1'b0;
            mm_start_reg  <= 1'b0;
        end
        else
        begin
            mm_start_reg <= 1'b0;
            if (cfg_wen)
            begin
                p_reg <= cfg_wdata[WIDTH-1:0];
            end
            if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        n_reg     <= s_axis_tdata;
                        state_reg <= ST_INIT;
                    end
                end
                ST_INIT:
                begin
                    if (bad_input)
                    begin
                        res_reg   <= '0;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        q_reg     <= p_reg - 1'b1;
                        s_reg     <= '0;
                        state_reg <= ST_FACTOR;
                    end
                end
                ST_FACTOR:
                begin
                    if (!q_reg[0])
                    begin
                        q_reg <= q_reg >> 1;
                        s_reg <= s_reg + 1'b1;
                    end
                    else if (s_reg == SW'(1))
                    begin
                        base_reg    <= n_low;
                        exp_reg     <= (p_reg >> 2) + 1'b1;
                        pacc_reg    <= WIDTH'(1);
                        pow_ret_reg <= ST_S1_SQ;
                        state_reg   <= ST_POW_CHK;
                    end
                    else
                    begin
                        z_reg     <= WIDTH'(2);
                        state_reg <= ST_ZCHK;
                    end
                end
                // square-and-multiply, exponent taken from the low bit up
                ST_POW_CHK:
                begin
                    if (exp_reg == '0)
                    begin
                        state_reg <= pow_ret_reg;
                    end
                    else
                    begin
                        mm_start_reg <= 1'b1;
                        state_reg    <= ST_MWAIT;
                        if (exp_reg[0])
                        begin
                            mma_reg <= pacc_reg;
                            mmb_reg <= base_reg;
                            ret_reg <= ST_POW_ACC;
                        end
                        else
                        begin
                            mma_reg <= base_reg;
                            mmb_reg <= base_reg;
                            ret_reg <= ST_POW_SQ;
                        end
                    end
                end
                ST_POW_ACC:
                begin
                    pacc_reg     <= mm_prod;
                    mm_start_reg <= 1'b1;
                    mma_reg      <= base_reg;
                    mmb_reg      <= base_reg;
                    ret_reg      <= ST_POW_SQ;
                    state_reg    <= ST_MWAIT;
                end
                ST_POW_SQ:
                begin
                    base_reg  <= mm_prod;
                    exp_reg   <= exp_reg >> 1;
                    state_reg <= ST_POW_CHK;
                end
                ST_MWAIT:
                begin
                    if (mm_stat.done)
                    begin
                        state_reg <= ret_reg;
                    end
                end
                ST_S1_SQ:
                begin
                    r_reg        <= pacc_reg;
                    mm_start_reg <= 1'b1;
                    mma_reg      <= pacc_reg;
                    mmb_reg      <= pacc_reg;
                    ret_reg      <= ST_FIN;
                    state_reg    <= ST_MWAIT;
                end
                ST_ZCHK:
                begin
                    if (z_reg >= p_reg || 64'(z_reg) > 64'(NONRES_LIMIT))
                    begin
                        res_reg   <= '0;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        base_reg    <= z_reg;
                        exp_reg     <= p_reg >> 1;
                        pacc_reg    <= WIDTH'(1);
                        pow_ret_reg <= ST_ZTEST;
                        state_reg   <= ST_POW_CHK;
                    end
                end
                ST_ZTEST:
                begin
                    if (pacc_reg == p_reg - 1'b1)
                    begin
                        base_reg    <= z_reg;
                        exp_reg     <= q_reg;
                        pacc_reg    <= WIDTH'(1);
                        pow_ret_reg <= ST_GOT_C;
                        state_reg   <= ST_POW_CHK;
                    end
                    else
                    begin
                        z_reg     <= z_reg + 1'b1;
                        state_reg <= ST_ZCHK;
                    end
                end
                ST_GOT_C:
                begin
                    c_reg       <= pacc_reg;
                    base_reg    <= n_low;
                    exp_reg     <= (q_reg >> 1) + 1'b1;
                    pacc_reg    <= WIDTH'(1);
                    pow_ret_reg <= ST_GOT_R;
                    state_reg   <= ST_POW_CHK;
                end
                ST_GOT_R:
                begin
                    r_reg       <= pacc_reg;
                    base_reg    <= n_low;
                    exp_reg     <= q_reg;
                    pacc_reg    <= WIDTH'(1);
                    pow_ret_reg <= ST_GOT_T;
                    state_reg   <= ST_POW_CHK;
                end
                ST_GOT_T:
                begin
                    t_reg     <= pacc_reg;
                    m_reg     <= s_reg;
                    state_reg <= ST_LOOP;
                end
                ST_LOOP:
                begin
                    mm_start_reg <= 1'b1;
                    state_reg    <= ST_MWAIT;
                    if (t_reg == WIDTH'(1))
                    begin
                        mma_reg <= r_reg;
                        mmb_reg <= r_reg;
                        ret_reg <= ST_FIN;
                    end
                    else
                    begin
                        i_reg   <= '0;
                        mma_reg <= t_reg;
                        mmb_reg <= t_reg;
                        ret_reg <= ST_TT_SQ;
                    end
                end
                // find the least i with t^(2^i) = 1
                ST_TT_SQ:
                begin
                    i_reg <= i_next;
                    if (i_next == m_reg)
                    begin
                        res_reg   <= '0;
                        state_reg <= ST_OUT;
                    end
                    else if (mm_prod == WIDTH'(1))
                    begin
                        cnt_reg   <= m_reg - i_next - 1'b1;
                        b_reg     <= c_reg;
                        state_reg <= ST_BSQ;
                    end
                    else
                    begin
                        mm_start_reg <= 1'b1;
                        mma_reg      <= mm_prod;
                        mmb_reg      <= mm_prod;
                        ret_reg      <= ST_TT_SQ;
                        state_reg    <= ST_MWAIT;
                    end
                end
                ST_BSQ:
                begin
                    mm_start_reg <= 1'b1;
                    mma_reg      <= b_reg;
                    mmb_reg      <= b_reg;
                    state_reg    <= ST_MWAIT;
                    if (cnt_reg == '0)
                    begin
                        ret_reg <= ST_B2;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                        ret_reg <= ST_BSQ_R;
                    end
                end
                ST_BSQ_R:
                begin
                    b_reg     <= mm_prod;
                    state_reg <= ST_BSQ;
                end
                ST_B2:
                begin
                    b2_reg       <= mm_prod;
                    mm_start_reg <= 1'b1;
                    mma_reg      <= r_reg;
                    mmb_reg      <= b_reg;
                    ret_reg      <= ST_UPD_R;
                    state_reg    <= ST_MWAIT;
                end
                ST_UPD_R:
                begin
                    r_reg        <= mm_prod;
                    mm_start_reg <= 1'b1;
                    mma_reg      <= t_reg;
                    mmb_reg      <= b2_reg;
                    ret_reg      <= ST_UPD_T;
                    state_reg    <= ST_MWAIT;
                end
                ST_UPD_T:
                begin
                    t_reg     <= mm_prod;
                    c_reg     <= b2_reg;
                    m_reg     <= i_reg;
                    state_reg <= ST_LOOP;
                end
                ST_FIN:
                begin
                    res_reg   <= (mm_prod == n_low) ? r_reg : '0;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && (!out_valid_reg || m_axis_tready))
        begin
            out_reg <= res_reg;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 64'(out_reg);

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mm_start_reg |-> !mm_stat.busy)
        else $error("multiply issued while unit busy");

    a_bsq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BSQ) |-> (i_reg < m_reg))
        else $error("squaring count out of range");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("pending result word lost");

    a_wait_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MWAIT && !mm_start_reg) |-> (mm_stat.busy || mm_stat.done))
        else $error("waiting on idle multiplier");

endmodule
